>>> hdl/quadtree_pyramid_argmax_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUADTREE_PYRAMID_ARGMAX_MACROS_SVH
`define QUADTREE_PYRAMID_ARGMAX_MACROS_SVH

// same-cycle implication
`define QPA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QPA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/qpa_pkg.sv
// ----------------------------------------------------------------------------
// qpa_pkg
// Sizes, codes, port structs and helper functions of the pyramid argmax.
// ----------------------------------------------------------------------------
package qpa_pkg;

   localparam int TOP_RES      = 64;
   localparam int RES_W        = $clog2(TOP_RES);
   localparam int TOP_CELLS    = TOP_RES * TOP_RES;
   localparam int TOP_AW       = $clog2(TOP_CELLS);
   localparam int LEVELS       = RES_W;
   localparam int LVL_W        = $clog2(LEVELS);
   localparam int COARSE_DEPTH = (TOP_CELLS - 4) / 3;
   localparam int COARSE_AW    = $clog2(COARSE_DEPTH);
   localparam int DATA_W       = 32;
   localparam int TOTAL_W      = DATA_W + TOP_AW;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_BUILD,
      ST_DRAIN,
      ST_DESC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                 we;
      logic [TOP_AW-1:0]    waddr;
      logic [DATA_W-1:0]    wdata;
      logic [TOP_AW-1:0]    raddr;
   } top_port_type;

   typedef struct packed {
      logic                 we;
      logic [COARSE_AW-1:0] waddr;
      logic [DATA_W-1:0]    wdata;
      logic [COARSE_AW-1:0] raddr;
   } coarse_port_type;

   typedef struct packed {
      logic              valid;
      logic              found;
      logic [TOP_AW-1:0] center;
   } result_type;

   // saturating signed add
   function automatic logic signed [DATA_W-1:0] sat_add(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return s[DATA_W-1:0];
   endfunction

   // address of cell (row, col) of coarse level k, levels packed finest first
   function automatic logic [COARSE_AW-1:0] coarse_addr(
      input logic [LVL_W-1:0] k,
      input logic [RES_W-1:0] row,
      input logic [RES_W-1:0] col);
      int unsigned acc;
      acc = 0;
      for (int i = 1; i < LEVELS; i++) begin
         if (i < int'(k)) acc += (TOP_RES >> i) * (TOP_RES >> i);
      end
      acc += (int'(row) << (RES_W - int'(k))) + int'(col);
      return COARSE_AW'(acc);
   endfunction

endpackage

>>> hdl/qpa_ram.sv
// ----------------------------------------------------------------------------
// qpa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module qpa_ram #(
   parameter int AW    = 12,
   parameter int DW    = 32,
   parameter int DEPTH = 4096
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/qpa_seq.sv
// ----------------------------------------------------------------------------
// qpa_seq
// Command sequencer: add, clear sweep, pyramid rebuild and max descent.
// ----------------------------------------------------------------------------
`include "quadtree_pyramid_argmax_macros.svh"

module qpa_seq import qpa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_command,
   input  logic [TOP_AW-1:0]        req_cell_index,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     out_free,
   output result_type               res,
   output top_port_type             top_port,
   input  logic [DATA_W-1:0]        top_rdata,
   output coarse_port_type          coarse_port,
   input  logic [DATA_W-1:0]        coarse_rdata
);

   localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);
   localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);
   localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   state_type                state_ff, state_in;
   logic [LVL_W-1:0]         lvl_ff, lvl_in;
   logic [RES_W-1:0]         row_ff, row_in, col_ff, col_in;
   logic [1:0]               q_ff, q_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic [TOP_AW-1:0]        clr_ff, clr_in;
   logic [TOP_AW-1:0]        add_idx_ff, add_idx_in;
   logic signed [DATA_W-1:0] add_val_ff, add_val_in;
   logic                     stale_ff, stale_in;
   logic                     zero_ff, zero_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic [DATA_W-1:0]        acc_ff, acc_in;
   logic                     tag_valid_ff, tag_valid_in;
   logic                     tag_build_ff, tag_build_in;
   logic                     tag_top_ff, tag_top_in;
   logic [1:0]               tag_q_ff, tag_q_in;
   logic [COARSE_AW-1:0]     tag_waddr_ff, tag_waddr_in;
   logic signed [DATA_W-1:0] bval_ff, bval_in;
   logic [1:0]               bq_ff, bq_in;
   logic                     found_ff, found_in;
   logic [TOP_AW-1:0]        cell_ff, cell_in;

   logic signed [DATA_W-1:0] rdata;
   logic [DATA_W-1:0]        pos, acc_sum, acc_new;
   logic                     take_new;
   logic signed [DATA_W-1:0] sel_val;
   logic [1:0]               sel_q;
   logic [RES_W-1:0]         last_coord, crow, ccol, nrow, ncol;
   logic                     zero_now;

   // returning read data and its bookkeeping
   always_comb begin
      rdata    = tag_top_ff ? top_rdata : coarse_rdata;
      pos      = (rdata > 0) ? rdata : '0;
      acc_sum  = acc_ff + pos;
      acc_new  = (tag_q_ff == 2'd0) ? pos : (acc_sum[DATA_W-1] ? POS_MAX : acc_sum);
      take_new = (tag_q_ff == 2'd0) || (rdata > bval_ff);
      sel_val  = take_new ? rdata : bval_ff;
      sel_q    = take_new ? tag_q_ff : bq_ff;
      nrow     = {row_ff[RES_W-2:0], sel_q[1]};
      ncol     = {col_ff[RES_W-2:0], sel_q[0]};
      last_coord = RES_W'((TOP_RES >> lvl_ff) - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         stale_ff     <= 1'b1;
         zero_ff      <= 1'b0;
         tag_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         stale_ff     <= stale_in;
         zero_ff      <= zero_in;
         tag_valid_ff <= tag_valid_in;
      end
      lvl_ff       <= lvl_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      q_ff         <= q_in;
      cnt_ff       <= cnt_in;
      add_idx_ff   <= add_idx_in;
      add_val_ff   <= add_val_in;
      total_ff     <= total_in;
      acc_ff       <= acc_in;
      tag_build_ff <= tag_build_in;
      tag_top_ff   <= tag_top_in;
      tag_q_ff     <= tag_q_in;
      tag_waddr_ff <= tag_waddr_in;
      bval_ff      <= bval_in;
      bq_ff        <= bq_in;
      found_ff     <= found_in;
      cell_ff      <= cell_in;
   end

   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      add_idx_in   = add_idx_ff;
      add_val_in   = add_val_ff;
      stale_in     = stale_ff;
      zero_in      = zero_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      tag_valid_in = 1'b0;
      tag_build_in = tag_build_ff;
      tag_top_in   = tag_top_ff;
      tag_q_in     = tag_q_ff;
      tag_waddr_in = tag_waddr_ff;
      bval_in      = bval_ff;
      bq_in        = bq_ff;
      found_in     = found_ff;
      cell_in      = cell_ff;
      crow         = '0;
      ccol         = '0;
      zero_now     = zero_ff;
      req_ready    = 1'b0;
      res          = '{valid: 1'b0, found: found_ff, center: cell_ff};
      top_port     = '{we: 1'b0, waddr: add_idx_ff, wdata: '0, raddr: req_cell_index};
      coarse_port  = '{we: 1'b0, waddr: tag_waddr_ff, wdata: acc_new, raddr: '0};

      // retire the read issued last cycle
      if (tag_valid_ff && tag_build_ff) begin
         acc_in = acc_new;
         if (tag_top_ff) total_in = total_ff + TOTAL_W'(rdata);
         if (tag_q_ff == 2'd3) coarse_port.we = 1'b1;
      end
      if (tag_valid_ff && !tag_build_ff) begin
         bval_in = sel_val;
         bq_in   = sel_q;
      end

      case (state_ff)
         ST_CLEAR: begin
            top_port.we    = 1'b1;
            top_port.waddr = clr_ff;
            clr_in         = clr_ff + 1'b1;
            if (clr_ff == TOP_AW'(TOP_CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_command)
                  CMD_ADD: begin
                     if ({1'b0, req_cell_index} < (TOP_AW+1)'(TOP_CELLS)) begin
                        add_idx_in = req_cell_index;
                        add_val_in = req_value;
                        stale_in   = 1'b1;
                        state_in   = ST_ADD;
                     end
                  end
                  CMD_CLEAR: begin
                     clr_in   = '0;
                     stale_in = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  CMD_QUERY: begin
                     row_in = '0;
                     col_in = '0;
                     if (stale_ff) begin
                        lvl_in   = LVL_ONE;
                        q_in     = '0;
                        total_in = '0;
                        state_in = ST_BUILD;
                     end else if (zero_ff) begin
                        found_in = 1'b0;
                        cell_in  = '0;
                        state_in = ST_RESP;
                     end else begin
                        lvl_in   = LVL_LAST;
                        cnt_in   = '0;
                        state_in = ST_DESC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            top_port.we    = 1'b1;
            top_port.wdata = sat_add(top_rdata, add_val_ff);
            state_in       = ST_IDLE;
         end
         ST_BUILD: begin
            crow         = {row_ff[RES_W-2:0], q_ff[1]};
            ccol         = {col_ff[RES_W-2:0], q_ff[0]};
            top_port.raddr    = {crow, ccol};
            coarse_port.raddr = coarse_addr(lvl_ff - 1'b1, crow, ccol);
            tag_valid_in = 1'b1;
            tag_build_in = 1'b1;
            tag_top_in   = (lvl_ff == LVL_ONE);
            tag_q_in     = q_ff;
            tag_waddr_in = coarse_addr(lvl_ff, row_ff, col_ff);
            q_in         = q_ff + 1'b1;
            if (q_ff == 2'd3) begin
               if (col_ff == last_coord) begin
                  col_in = '0;
                  if (row_ff == last_coord) begin
                     row_in   = '0;
                     state_in = ST_DRAIN;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (lvl_ff == LVL_ONE) begin
               zero_now = (total_in == '0);
               zero_in  = zero_now;
            end
            if (lvl_ff == LVL_LAST) begin
               stale_in = 1'b0;
               if (zero_now) begin
                  found_in = 1'b0;
                  cell_in  = '0;
                  state_in = ST_RESP;
               end else begin
                  cnt_in   = '0;
                  state_in = ST_DESC;
               end
            end else begin
               lvl_in   = lvl_ff + 1'b1;
               q_in     = '0;
               state_in = ST_BUILD;
            end
         end
         ST_DESC: begin
            if (!cnt_ff[2]) begin
               crow              = {row_ff[RES_W-2:0], cnt_ff[1]};
               ccol              = {col_ff[RES_W-2:0], cnt_ff[0]};
               top_port.raddr    = {crow, ccol};
               coarse_port.raddr = coarse_addr(lvl_ff, crow, ccol);
               tag_valid_in      = 1'b1;
               tag_build_in      = 1'b0;
               tag_top_in        = (lvl_ff == '0);
               tag_q_in          = cnt_ff[1:0];
               cnt_in            = cnt_ff + 1'b1;
            end else begin
               if (lvl_ff == LVL_LAST && sel_val <= 0) begin
                  found_in = 1'b0;
                  cell_in  = '0;
                  state_in = ST_RESP;
               end else if (lvl_ff == '0) begin
                  found_in = 1'b1;
                  cell_in  = {nrow, ncol};
                  state_in = ST_RESP;
               end else begin
                  lvl_in = lvl_ff - 1'b1;
                  row_in = nrow;
                  col_in = ncol;
                  cnt_in = '0;
               end
            end
         end
         ST_RESP: begin
            res.valid = out_free;
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // the first level reads the grid memory, so the coarse read port is unused there
   `QPA_ASSERT_IMP(a_notfound_zero, res.valid && !res.found, res.center == '0, "cell not zero")
   `QPA_ASSERT_IMP(a_res_free, res.valid, out_free, "result while output busy")
   `QPA_ASSERT_NXT(a_add_writes, req_valid && req_ready && req_command == CMD_ADD,
      top_port.we, "add not written back")
   `QPA_ASSERT_IMP(a_no_rw_clash, coarse_port.we && state_ff == ST_BUILD && lvl_ff != LVL_ONE,
      coarse_port.waddr != coarse_port.raddr, "coarse read/write overlap")

endmodule

>>> hdl/quadtree_pyramid_argmax.sv
// Operation: an add reads the cell and writes back the saturated sum; a clear
// sweeps the grid to zero; a query descends six levels of four reads and a
// pick, then loads the output register, after a pyramid rebuild when stale.
// Transactions: one at a time, set by the single read port of each memory;
// a new add is not accepted until the previous one has been written back.
// Reset: synchronous; the grid memory is swept to zero, during which no
// request is accepted.
// ----------------------------------------------------------------------------
// quadtree_pyramid_argmax
// Accumulator grid with a summed 2x2 pyramid and hierarchical max search.
// ----------------------------------------------------------------------------
module quadtree_pyramid_argmax import qpa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_command,
   input  logic [TOP_AW-1:0]        req_cell_index,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_found,
   output logic [TOP_AW-1:0]        rsp_center_cell
);

   top_port_type    top_port;
   coarse_port_type coarse_port;
   result_type      res;
   logic [DATA_W-1:0] top_rdata, coarse_rdata;
   logic            out_free;

   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [TOP_AW-1:0] rsp_cell_ff;

   // top grid: one 32-bit accumulator per cell
   qpa_ram #(.AW(TOP_AW), .DW(DATA_W), .DEPTH(TOP_CELLS)) u_top_ram (
      .clock (clock),
      .we    (top_port.we),
      .waddr (top_port.waddr),
      .wdata (top_port.wdata),
      .raddr (top_port.raddr),
      .rdata (top_rdata)
   );

   // coarse levels 32x32 down to 2x2, packed finest first
   qpa_ram #(.AW(COARSE_AW), .DW(DATA_W), .DEPTH(COARSE_DEPTH)) u_coarse_ram (
      .clock (clock),
      .we    (coarse_port.we),
      .waddr (coarse_port.waddr),
      .wdata (coarse_port.wdata),
      .raddr (coarse_port.raddr),
      .rdata (coarse_rdata)
   );

   qpa_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_cell_index (req_cell_index),
      .req_value      (req_value),
      .out_free       (out_free),
      .res            (res),
      .top_port       (top_port),
      .top_rdata      (top_rdata),
      .coarse_port    (coarse_port),
      .coarse_rdata   (coarse_rdata)
   );

   // the output register is free once empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // hold the result until the consumer takes the transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res.valid) begin
         rsp_found_ff <= res.found;
         rsp_cell_ff  <= res.center;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_center_cell = rsp_cell_ff;

endmodule
